// File: sv/sensor_reading_monitor_unit_macros.svh
// Assertion macros shared by the sensor reading monitor RTL.
`ifndef SENSOR_READING_MONITOR_UNIT_MACROS_SVH
`define SENSOR_READING_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SRM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/srm_pkg.sv
// Shared types, codes and constants of the sensor reading monitor.
`timescale 1ns / 1ps

package srm_pkg;

   localparam int NUM_SENSORS_DEF = 16;
   localparam int NUM_SAMPLES_DEF = 8;
   localparam int QUEUE_DEPTH     = 2;
   localparam int VAL_W           = 16;
   localparam int SUM_OUT_W       = 19;
   localparam int SUM_OUT_MAX     = 262143;
   localparam int SUM_OUT_MIN     = -262144;
   // op + sample number + code + reading; slot and row widths come on top
   localparam int CMD_FIXED_W     = 2 + 4 + 16 + 16;

   localparam logic signed [VAL_W-1:0] LOW_LIMIT_RESET  = -16'sd10;
   localparam logic signed [VAL_W-1:0] HIGH_LIMIT_RESET = 16'sd60;

   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_MEASURE = 2'd1,
      REQ_REPORT  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_ALARM  = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_ERROR  = 2'd2
   } rsp_kind_type;

   typedef enum logic [1:0] {
      CMD_STORE,
      CMD_ALARM,
      CMD_ERROR,
      CMD_REPORT
   } cmd_op_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SUM,
      BK_EMIT
   } back_state_type;

   typedef enum logic {
      REG_LOW_LIMIT  = 1'b0,
      REG_HIGH_LIMIT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic clearing;
      logic report_done;
   } back_status_type;

   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

// File: sv/srm_queue.sv
// Small first-word-fall-through command queue between front and back.
`timescale 1ns / 1ps

module srm_queue import srm_pkg::*; #(
   parameter int WIDTH = CMD_FIXED_W,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PTR_W = idx_width(DEPTH),
   localparam int CNT_W = idx_width(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (int'(count_ff) == DEPTH);
   assign empty = (count_ff == '0);
   assign rdata = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: sv/srm_front.sv
// Front end: takes request transactions, keeps the sensor table, classifies measurements.
`timescale 1ns / 1ps

module srm_front import srm_pkg::*; #(
   parameter int NUM_SENSORS = NUM_SENSORS_DEF,
   parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
   localparam int SLOT_W = idx_width(NUM_SENSORS),
   localparam int ROW_W  = idx_width(NUM_SAMPLES),
   localparam int CMD_W  = CMD_FIXED_W + SLOT_W + ROW_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_req_type,
   input  logic [3:0]              req_slot_index,
   input  logic [15:0]             req_sensor_code,
   input  logic                    req_sensor_active,
   input  logic [3:0]              req_sample_number,
   input  logic signed [VAL_W-1:0] req_temperature,
   input  logic signed [VAL_W-1:0] low_limit,
   input  logic signed [VAL_W-1:0] high_limit,
   input  back_status_type         status,
   input  logic                    q_full,
   output logic                    q_push,
   output logic [CMD_W-1:0]        q_wdata,
   input  logic [SLOT_W-1:0]       rpt_col,
   output logic [15:0]             rpt_code
);

   localparam int RPT_W = idx_width(QUEUE_DEPTH + 2);

   typedef struct packed {
      cmd_op_type              op;
      logic [SLOT_W-1:0]       pos;
      logic [ROW_W-1:0]        row;
      logic [3:0]              sample;
      logic [15:0]             code;
      logic signed [VAL_W-1:0] temp;
   } cmd_type;

   logic                    hold_valid_ff, hold_valid_in;
   logic [1:0]              hold_type_ff;
   logic [3:0]              hold_slot_ff;
   logic [15:0]             hold_code_ff;
   logic                    hold_active_ff;
   logic [3:0]              hold_sample_ff;
   logic signed [VAL_W-1:0] hold_temp_ff;

   logic [15:0]             code_ff [NUM_SENSORS];
   logic [NUM_SENSORS-1:0]  loaded_ff, active_ff;
   logic [RPT_W-1:0]        rpt_cnt_ff, rpt_cnt_in;

   logic                    match_hit;
   logic [SLOT_W-1:0]       match_pos;
   logic                    sample_ok, load_ok, over_limit;
   logic [SLOT_W-1:0]       load_idx;
   logic                    table_we, item_done, rpt_push;
   cmd_type                 cmd;

   assign req_ready = !hold_valid_ff && !status.clearing;
   assign rpt_code  = loaded_ff[rpt_col] ? code_ff[rpt_col] : '0;

   // lowest loaded slot with a matching code wins
   always_comb begin
      match_hit = 1'b0;
      match_pos = '0;
      for (int i = NUM_SENSORS - 1; i >= 0; i--) begin
         if (loaded_ff[i] && (code_ff[i] == hold_code_ff)) begin
            match_hit = 1'b1;
            match_pos = SLOT_W'(i);
         end
      end
   end

   assign sample_ok  = (hold_sample_ff != 4'd0) && (int'(hold_sample_ff) <= NUM_SAMPLES);
   assign load_ok    = (int'(hold_slot_ff) < NUM_SENSORS);
   assign load_idx   = SLOT_W'(hold_slot_ff);
   assign over_limit = (hold_temp_ff > high_limit) || (hold_temp_ff < low_limit);

   always_comb begin
      cmd.pos    = match_pos;
      cmd.row    = ROW_W'(hold_sample_ff - 4'd1);
      cmd.sample = hold_sample_ff;
      cmd.code   = hold_code_ff;
      cmd.temp   = hold_temp_ff;
      if (hold_type_ff == REQ_REPORT) begin
         cmd.op = CMD_REPORT;
      end else if (!match_hit || !sample_ok) begin
         cmd.op = CMD_ERROR;
      end else if (active_ff[match_pos] && over_limit) begin
         cmd.op = CMD_ALARM;
      end else begin
         cmd.op = CMD_STORE;
      end
   end

   assign q_wdata = cmd;

   always_comb begin
      table_we  = 1'b0;
      item_done = 1'b0;
      q_push    = 1'b0;
      if (hold_valid_ff) begin
         unique case (hold_type_ff)
            REQ_LOAD: begin
               // hold loads while a report still has to read the table
               if (rpt_cnt_ff == '0) begin
                  table_we  = load_ok;
                  item_done = 1'b1;
               end
            end
            REQ_MEASURE, REQ_REPORT: begin
               if (!q_full) begin
                  q_push    = 1'b1;
                  item_done = 1'b1;
               end
            end
            default: begin
               item_done = 1'b1;
            end
         endcase
      end
   end

   assign rpt_push = q_push && (hold_type_ff == REQ_REPORT);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (item_done) begin
         hold_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         hold_valid_in = 1'b1;
      end
      rpt_cnt_in = rpt_cnt_ff + RPT_W'(rpt_push) - RPT_W'(status.report_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rpt_cnt_ff    <= '0;
         loaded_ff     <= '0;
         active_ff     <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rpt_cnt_ff    <= rpt_cnt_in;
         if (table_we) begin
            loaded_ff[load_idx] <= 1'b1;
            active_ff[load_idx] <= hold_active_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_type_ff   <= req_req_type;
         hold_slot_ff   <= req_slot_index;
         hold_code_ff   <= req_sensor_code;
         hold_active_ff <= req_sensor_active;
         hold_sample_ff <= req_sample_number;
         hold_temp_ff   <= req_temperature;
      end
      if (table_we) begin
         code_ff[load_idx] <= hold_code_ff;
      end
   end

endmodule

// File: sv/srm_back.sv
// Back end: sample store, alarm and error results, report walk and result register.
`timescale 1ns / 1ps

module srm_back import srm_pkg::*; #(
   parameter int NUM_SENSORS = NUM_SENSORS_DEF,
   parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
   localparam int SLOT_W = idx_width(NUM_SENSORS),
   localparam int ROW_W  = idx_width(NUM_SAMPLES),
   localparam int CMD_W  = CMD_FIXED_W + SLOT_W + ROW_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  logic [CMD_W-1:0]            q_rdata,
   output logic                        q_pop,
   output logic [SLOT_W-1:0]           rpt_col,
   input  logic [15:0]                 rpt_code,
   output back_status_type             status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [3:0]                  rsp_slot,
   output logic [15:0]                 rsp_code_out,
   output logic [3:0]                  rsp_sample_out,
   output logic signed [VAL_W-1:0]     rsp_value_out,
   output logic signed [VAL_W-1:0]     rsp_min_temperature,
   output logic signed [SUM_OUT_W-1:0] rsp_sample_sum,
   output logic                        rsp_is_best,
   output logic                        rsp_last
);

   localparam int ADDR_W = ROW_W + SLOT_W;
   localparam int ACC_W  = SUM_OUT_W + idx_width(NUM_SAMPLES);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SUM_OUT_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SUM_OUT_MIN);

   typedef struct packed {
      cmd_op_type              op;
      logic [SLOT_W-1:0]       pos;
      logic [ROW_W-1:0]        row;
      logic [3:0]              sample;
      logic [15:0]             code;
      logic signed [VAL_W-1:0] temp;
   } cmd_type;

   cmd_type                     head;
   back_state_type              state_ff, state_in;

   logic signed [VAL_W-1:0]     store_mem [2**ADDR_W];
   logic signed [VAL_W-1:0]     rd_data_ff;
   logic                        mem_we;
   logic [ADDR_W-1:0]           mem_waddr;
   logic signed [VAL_W-1:0]     mem_wdata;

   logic [ADDR_W-1:0]           clr_addr_ff, clr_addr_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [SLOT_W-1:0]           col_ff, col_in;
   logic                        phase_ff, phase_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in, acc_next, cell_ext;
   logic signed [VAL_W-1:0]     min_ff, min_in, min_next;
   logic signed [ACC_W-1:0]     best_sum_ff, best_sum_in;
   logic [SLOT_W-1:0]           best_col_ff, best_col_in;
   logic signed [SUM_OUT_W-1:0] sum_sat;
   logic                        first_row, last_row, last_col;

   logic                        rsp_valid_ff, out_free, out_load;
   logic [1:0]                  kind_ff, kind_in;
   logic [3:0]                  slot_ff, slot_in;
   logic [15:0]                 code_ff, code_in;
   logic [3:0]                  sample_ff, sample_in;
   logic signed [VAL_W-1:0]     value_ff, value_in;
   logic signed [VAL_W-1:0]     minout_ff, minout_in;
   logic signed [SUM_OUT_W-1:0] sum_ff, sum_in;
   logic                        best_ff, best_in;
   logic                        last_ff, last_in;
   logic                        report_done;

   assign head     = q_rdata;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rpt_col  = col_ff;

   assign status.clearing    = (state_ff == BK_CLEAR);
   assign status.report_done = report_done;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_slot            = slot_ff;
   assign rsp_code_out        = code_ff;
   assign rsp_sample_out      = sample_ff;
   assign rsp_value_out       = value_ff;
   assign rsp_min_temperature = minout_ff;
   assign rsp_sample_sum      = sum_ff;
   assign rsp_is_best         = best_ff;
   assign rsp_last            = last_ff;

   // column accumulate over the rows of one slot
   assign first_row = (row_ff == '0);
   assign last_row  = (int'(row_ff) == NUM_SAMPLES - 1);
   assign last_col  = (int'(col_ff) == NUM_SENSORS - 1);
   assign cell_ext  = ACC_W'(rd_data_ff);
   assign acc_next  = first_row ? cell_ext : acc_ff + cell_ext;
   assign min_next  = (first_row || (rd_data_ff < min_ff)) ? rd_data_ff : min_ff;

   always_comb begin
      if (acc_next > SAT_HI) begin
         sum_sat = SAT_HI[SUM_OUT_W-1:0];
      end else if (acc_next < SAT_LO) begin
         sum_sat = SAT_LO[SUM_OUT_W-1:0];
      end else begin
         sum_sat = acc_next[SUM_OUT_W-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      min_in      = min_ff;
      best_sum_in = best_sum_ff;
      best_col_in = best_col_ff;
      mem_we      = 1'b0;
      mem_waddr   = {head.row, head.pos};
      mem_wdata   = head.temp;
      q_pop       = 1'b0;
      out_load    = 1'b0;
      report_done = 1'b0;
      kind_in     = KIND_ERROR;
      slot_in     = '0;
      code_in     = head.code;
      sample_in   = head.sample;
      value_in    = head.temp;
      minout_in   = '0;
      sum_in      = '0;
      best_in     = 1'b0;
      last_in     = 1'b1;

      unique case (state_ff)
         BK_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               unique case (head.op) inside
                  CMD_STORE: begin
                     q_pop  = 1'b1;
                     mem_we = 1'b1;
                  end
                  CMD_ALARM, CMD_ERROR: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        out_load = 1'b1;
                        if (head.op == CMD_ALARM) begin
                           mem_we  = 1'b1;
                           kind_in = KIND_ALARM;
                           slot_in = 4'(head.pos);
                        end
                     end
                  end
                  CMD_REPORT: begin
                     q_pop    = 1'b1;
                     row_in   = '0;
                     col_in   = '0;
                     phase_in = 1'b0;
                     state_in = BK_SUM;
                  end
               endcase
            end
         end
         BK_SUM: begin
            // first pass: exact sums only, to find the best slot
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               acc_in   = acc_next;
               min_in   = min_next;
               if (last_row) begin
                  row_in = '0;
                  if ((col_ff == '0) || (acc_next > best_sum_ff)) begin
                     best_sum_in = acc_next;
                     best_col_in = col_ff;
                  end
                  if (last_col) begin
                     col_in   = '0;
                     state_in = BK_EMIT;
                  end else begin
                     col_in = col_ff + SLOT_W'(1);
                  end
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         BK_EMIT: begin
            // second pass: recompute each slot and hand out its row
            kind_in   = KIND_REPORT;
            slot_in   = 4'(col_ff);
            code_in   = rpt_code;
            sample_in = '0;
            value_in  = '0;
            minout_in = min_next;
            sum_in    = sum_sat;
            best_in   = (col_ff == best_col_ff);
            last_in   = last_col;
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (!last_row) begin
               phase_in = 1'b0;
               acc_in   = acc_next;
               min_in   = min_next;
               row_in   = row_ff + ROW_W'(1);
            end else if (out_free) begin
               out_load = 1'b1;
               phase_in = 1'b0;
               row_in   = '0;
               if (last_col) begin
                  col_in      = '0;
                  report_done = 1'b1;
                  state_in    = BK_IDLE;
               end else begin
                  col_in = col_ff + SLOT_W'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         phase_ff    <= phase_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      min_ff      <= min_in;
      best_sum_ff <= best_sum_in;
      best_col_ff <= best_col_in;
      if (out_load) begin
         kind_ff   <= kind_in;
         slot_ff   <= slot_in;
         code_ff   <= code_in;
         sample_ff <= sample_in;
         value_ff  <= value_in;
         minout_ff <= minout_in;
         sum_ff    <= sum_in;
         best_ff   <= best_in;
         last_ff   <= last_in;
      end
   end

   // sample store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[{row_ff, col_ff}];
   end

endmodule

// File: sv/sensor_reading_monitor_unit.sv
// Sensor reading monitor: limit registers, front end, command queue and back end.
`timescale 1ns / 1ps
`include "sensor_reading_monitor_unit_macros.svh"

// Usage:
//   req_* is the request channel (load a table slot, store a measurement, ask for a
//   report); rsp_* carries alarm, error and report-row transactions, rsp_last marks
//   the final row of each item. csr_* is an APB-style port for the low and high limit.
//   A load waits in the front holding register and writes the table from there. An
//   alarm or error result of a measurement passes the front holding register, the
//   command queue and the result register; the holding register, which does the table
//   lookup, takes no new request until its item is through. A report reads the sample
//   store twice through its single read port, rows leaving during the second pass.
//   Loads wait while a report is pending.
//   After reset the back end zeroes the sample store, one cell a cycle; req_ready
//   stays low meanwhile, limit writes are taken at once.
//   When rsp_ready is low the result register holds, the back end stops at its next
//   result, and the two-entry command queue then fills and stalls the front end.
module sensor_reading_monitor_unit import srm_pkg::*; #(
   parameter int NUM_SENSORS = NUM_SENSORS_DEF,
   parameter int NUM_SAMPLES = NUM_SAMPLES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_req_type,
   input  logic [3:0]                  req_slot_index,
   input  logic [15:0]                 req_sensor_code,
   input  logic                        req_sensor_active,
   input  logic [3:0]                  req_sample_number,
   input  logic signed [VAL_W-1:0]     req_temperature,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [3:0]                  rsp_slot,
   output logic [15:0]                 rsp_code_out,
   output logic [3:0]                  rsp_sample_out,
   output logic signed [VAL_W-1:0]     rsp_value_out,
   output logic signed [VAL_W-1:0]     rsp_min_temperature,
   output logic signed [SUM_OUT_W-1:0] rsp_sample_sum,
   output logic                        rsp_is_best,
   output logic                        rsp_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int SLOT_W = idx_width(NUM_SENSORS);
   localparam int ROW_W  = idx_width(NUM_SAMPLES);
   localparam int CMD_W  = CMD_FIXED_W + SLOT_W + ROW_W;

   logic signed [VAL_W-1:0] low_limit_ff, high_limit_ff;
   logic                    csr_write;
   csr_reg_type             csr_sel;

   back_status_type         bk_status;
   logic                    q_push, q_pop, q_full, q_empty;
   logic [CMD_W-1:0]        q_wdata, q_rdata;
   logic [SLOT_W-1:0]       rpt_col;
   logic [15:0]             rpt_code;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_sel)
         REG_LOW_LIMIT:  csr_prdata = 32'(low_limit_ff);
         REG_HIGH_LIMIT: csr_prdata = 32'(high_limit_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= LOW_LIMIT_RESET;
         high_limit_ff <= HIGH_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_LOW_LIMIT:  low_limit_ff  <= csr_pwdata[VAL_W-1:0];
            REG_HIGH_LIMIT: high_limit_ff <= csr_pwdata[VAL_W-1:0];
         endcase
      end
   end

   srm_front #(
      .NUM_SENSORS (NUM_SENSORS),
      .NUM_SAMPLES (NUM_SAMPLES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_req_type      (req_req_type),
      .req_slot_index    (req_slot_index),
      .req_sensor_code   (req_sensor_code),
      .req_sensor_active (req_sensor_active),
      .req_sample_number (req_sample_number),
      .req_temperature   (req_temperature),
      .low_limit         (low_limit_ff),
      .high_limit        (high_limit_ff),
      .status            (bk_status),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_wdata           (q_wdata),
      .rpt_col           (rpt_col),
      .rpt_code          (rpt_code)
   );

   srm_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   srm_back #(
      .NUM_SENSORS (NUM_SENSORS),
      .NUM_SAMPLES (NUM_SAMPLES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_rdata             (q_rdata),
      .q_pop               (q_pop),
      .rpt_col             (rpt_col),
      .rpt_code            (rpt_code),
      .status              (bk_status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_slot            (rsp_slot),
      .rsp_code_out        (rsp_code_out),
      .rsp_sample_out      (rsp_sample_out),
      .rsp_value_out       (rsp_value_out),
      .rsp_min_temperature (rsp_min_temperature),
      .rsp_sample_sum      (rsp_sample_sum),
      .rsp_is_best         (rsp_is_best),
      .rsp_last            (rsp_last)
   );

   `SRM_ASSERT_NOW(a_clear_blocks_req, bk_status.clearing, !req_ready, "request taken during store clear")
   `SRM_ASSERT_NOW(a_push_has_room, q_push, !q_full, "command pushed into a full queue")
   `SRM_ASSERT_NOW(a_pop_has_data, q_pop, !q_empty, "command popped from an empty queue")
   `SRM_ASSERT_NEXT(a_report_ends_last, bk_status.report_done, rsp_valid && rsp_last && (rsp_kind == KIND_REPORT), "report end without last row")

endmodule
